// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL files, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Implication checked in the clock cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/core/lct_pkg.sv -----
// Package with types, codes and defaults of the copy propagation table.
package lct_pkg;

  localparam int TABLE_DEPTH_DEF = 512;
  localparam int MAX_HOPS_DEF    = 16;

  localparam logic [1:0] ACT_ASSIGN = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] dest_name;
    logic [15:0] first_operand;
    logic        first_is_literal;
    logic [15:0] second_operand;
    logic        second_is_literal;
    logic        has_operator;
  } item_t;

  typedef struct packed {
    logic [15:0] first_operand_out;
    logic [15:0] second_operand_out;
    logic        first_replaced;
    logic        second_replaced;
  } result_t;

  typedef struct packed {
    logic [15:0] name;
    logic [15:0] source;
  } entry_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_SYM_A,
    DP_SYM_B,
    DP_RD_IDX,
    DP_RD_LAST,
    DP_HOP,
    DP_NEXT,
    DP_SAVE_A,
    DP_SAVE_B,
    DP_MOVE,
    DP_BIND
  } dp_cmd_t;

  typedef struct packed {
    logic at_end;
    logic name_hit;
    logic self_loop;
    logic dest_hit;
    logic hops_done;
    logic act_assign;
    logic act_clear;
    logic a_lit;
    logic resolve_b;
    logic want_bind;
  } dp_status_t;

endpackage

// ----- rtl/core/lct_ram.sv -----
// Generic single write port RAM with a registered read port.
module lct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/lct_datapath.sv -----
// Datapath of the copy propagation table: binding memory, fill count and operand registers.
module lct_datapath #(
  parameter int TABLE_DEPTH = lct_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_HOPS    = lct_pkg::MAX_HOPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lct_pkg::dp_cmd_t    cmd,
  input  lct_pkg::item_t      item_in,
  output lct_pkg::dp_status_t status,
  output lct_pkg::result_t    result
);
  import lct_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int HW = $clog2(MAX_HOPS + 1);

  item_t          item;
  logic [15:0]    sym;
  logic [15:0]    a_res;
  logic [15:0]    b_res;
  logic           a_rep;
  logic           b_rep;
  logic           cur_b;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  cnt;
  logic [HW-1:0]  hops;
  logic [CW-1:0]  last_cnt;
  logic           full;

  logic           we;
  logic           re;
  logic [IW-1:0]  waddr;
  logic [IW-1:0]  raddr;
  entry_t         wdata;
  entry_t         rdata;

  assign last_cnt = cnt - CW'(1);
  assign full     = (cnt == CW'(TABLE_DEPTH));

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = idx[IW-1:0];
    raddr = idx[IW-1:0];
    wdata = rdata;
    case (cmd)
      DP_RD_IDX: re = 1'b1;
      DP_RD_LAST: begin
        re    = 1'b1;
        raddr = last_cnt[IW-1:0];
      end
      DP_MOVE: we = 1'b1;
      DP_BIND: begin
        we    = !full;
        waddr = cnt[IW-1:0];
        wdata = '{name: item.dest_name, source: a_res};
      end
      default: ;
    endcase
  end

  lct_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (cmd)
        DP_LOAD: begin
          item  <= item_in;
          a_res <= '0;
          b_res <= '0;
          a_rep <= 1'b0;
          b_rep <= 1'b0;
        end
        DP_CLEAR: cnt <= '0;
        DP_SYM_A: begin
          sym   <= item.first_operand;
          cur_b <= 1'b0;
          hops  <= '0;
          idx   <= '0;
        end
        DP_SYM_B: begin
          sym   <= item.second_operand;
          cur_b <= 1'b1;
          hops  <= '0;
          idx   <= '0;
        end
        DP_HOP: begin
          sym  <= rdata.source;
          hops <= hops + HW'(1);
          idx  <= '0;
          if (cur_b) begin
            b_rep <= 1'b1;
          end else begin
            a_rep <= 1'b1;
          end
        end
        DP_NEXT: idx <= idx + CW'(1);
        DP_SAVE_A: a_res <= sym;
        DP_SAVE_B: begin
          b_res <= sym;
          idx   <= '0;
        end
        DP_MOVE: cnt <= last_cnt;
        DP_BIND: begin
          if (!full) begin
            cnt <= cnt + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign status.at_end     = (idx == cnt);
  assign status.name_hit   = (rdata.name == sym);
  assign status.self_loop  = (rdata.source == sym);
  assign status.dest_hit   = (rdata.name == item.dest_name) || (rdata.source == item.dest_name);
  assign status.hops_done  = (hops == HW'(MAX_HOPS));
  assign status.act_assign = (item.action == ACT_ASSIGN);
  assign status.act_clear  = (item.action == ACT_CLEAR);
  assign status.a_lit      = item.first_is_literal;
  assign status.resolve_b  = item.has_operator && !item.second_is_literal;
  assign status.want_bind  = !item.has_operator && (a_rep || !item.first_is_literal);

  assign result = '{first_operand_out: a_res, second_operand_out: b_res,
                    first_replaced: a_rep, second_replaced: b_rep};

endmodule

// ----- rtl/core/lct_ctrl.sv -----
// Controller state machine that sequences resolution, removal and insertion.
module lct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lct_pkg::dp_status_t status,
  output lct_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done
);
  import lct_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RES_HEAD,
    S_RES_CHK,
    S_RES_END,
    S_B_START,
    S_INV_HEAD,
    S_INV_CHK,
    S_INV_MOVE,
    S_BIND,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   cur_b;
  logic   cur_b_next;

  always_comb begin
    state_next = state;
    cur_b_next = cur_b;
    cmd        = DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd        = DP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cur_b_next = 1'b0;
        if (status.act_clear) begin
          cmd        = DP_CLEAR;
          state_next = S_DONE;
        end else if (!status.act_assign) begin
          state_next = S_DONE;
        end else begin
          cmd        = DP_SYM_A;
          state_next = status.a_lit ? S_RES_END : S_RES_HEAD;
        end
      end
      S_RES_HEAD: begin
        if (status.hops_done || status.at_end) begin
          state_next = S_RES_END;
        end else begin
          cmd        = DP_RD_IDX;
          state_next = S_RES_CHK;
        end
      end
      S_RES_CHK: begin
        state_next = S_RES_HEAD;
        if (status.name_hit) begin
          if (status.self_loop) begin
            state_next = S_RES_END;
          end else begin
            cmd = DP_HOP;
          end
        end else begin
          cmd = DP_NEXT;
        end
      end
      S_RES_END: begin
        if (cur_b) begin
          cmd        = DP_SAVE_B;
          state_next = S_INV_HEAD;
        end else begin
          cmd        = DP_SAVE_A;
          state_next = S_B_START;
        end
      end
      S_B_START: begin
        cmd        = DP_SYM_B;
        cur_b_next = 1'b1;
        state_next = status.resolve_b ? S_RES_HEAD : S_RES_END;
      end
      S_INV_HEAD: begin
        if (status.at_end) begin
          state_next = S_BIND;
        end else begin
          cmd        = DP_RD_IDX;
          state_next = S_INV_CHK;
        end
      end
      S_INV_CHK: begin
        if (status.dest_hit) begin
          cmd        = DP_RD_LAST;
          state_next = S_INV_MOVE;
        end else begin
          cmd        = DP_NEXT;
          state_next = S_INV_HEAD;
        end
      end
      S_INV_MOVE: begin
        cmd        = DP_MOVE;
        state_next = S_INV_HEAD;
      end
      S_BIND: begin
        if (status.want_bind) begin
          cmd = DP_BIND;
        end
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur_b <= 1'b0;
    end else begin
      state <= state_next;
      cur_b <= cur_b_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ----- rtl/core/local_copy_propagation_table.sv -----
// Top level of the local copy propagation table.
// A barrier or skip passes only through decode and done; an assignment walks the table
// entries in each lookup hop and in the removal sweep, and moves the last entry per removal.
// Throughput: one instruction at a time; busy stays high until the result strobe has ended.
// The bindings live in one memory with one read port, compacted below a fill count.
// Synchronous reset empties the table at once through the fill count.
module local_copy_propagation_table #(
  parameter int TABLE_DEPTH = lct_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_HOPS    = lct_pkg::MAX_HOPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lct_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output lct_pkg::result_t result
);
  import lct_pkg::*;
  `include "assert_macros.svh"

  dp_cmd_t    cmd;
  dp_status_t status;

  lct_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  lct_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_HOPS   (MAX_HOPS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .item_in (item),
    .status  (status),
    .result  (result)
  );

  `ASSERT_NEXT(a_done_single, clk, rst, done, !done, "Result strobe lasted more than one cycle.")
  `ASSERT_IMPLIES(a_done_busy, clk, rst, done, busy, "Result strobe while the block was idle.")
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy && !done, "Transfer not followed by work.")

endmodule
